@@ src/sbs_pkg.sv @@
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants for the sorted key table with binary search.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_W       = 32;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND   = 2'd0,
        ST_MISSING = 2'd1,
        ST_DONE    = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic ins;
        logic capture;
    } t_cell_ctl;

    typedef struct packed {
        logic done;
        logic found;
    } t_srch_res;

endpackage

@@ src/sbs_in_if.sv @@
// ----------------------------------------------------------------------------
// sbs_in_if
// Request channel: action and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbs_in_if;
    logic                              valid;
    logic                              ready;
    logic [sbs_pkg::ACTION_W-1:0]      action;
    logic signed [sbs_pkg::KEY_W-1:0]  key_value;

    modport source (output valid, output action, output key_value, input ready);
    modport sink   (input valid, input action, input key_value, output ready);
endinterface

@@ src/sbs_out_if.sv @@
// ----------------------------------------------------------------------------
// sbs_out_if
// Response channel: status and position, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbs_out_if;
    logic                          valid;
    logic                          ready;
    logic [sbs_pkg::STATUS_W-1:0]  status;
    logic [sbs_pkg::POS_W-1:0]     position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);
endinterface

@@ src/sbs_cell.sv @@
// ----------------------------------------------------------------------------
// sbs_cell
// One table slot: holds a key, compares it against the broadcast key, takes
// its left neighbor's key on a shifting insert and latches compare flags
// for the search.
// ----------------------------------------------------------------------------
module sbs_cell (
    input  logic                              i_clk,
    input  sbs_pkg::t_cell_ctl                i_ctl,
    input  logic signed [sbs_pkg::KEY_W-1:0]  i_key,
    input  logic signed [sbs_pkg::KEY_W-1:0]  i_left_key,
    input  logic                              i_left_gt,
    input  logic                              i_in_use,
    input  logic                              i_at_end,
    output logic signed [sbs_pkg::KEY_W-1:0]  o_key,
    output logic                              o_gt,
    output logic                              o_eq_flag,
    output logic                              o_gt_flag
);

    logic signed [sbs_pkg::KEY_W-1:0] r_key;
    logic signed [sbs_pkg::KEY_W-1:0] n_key;
    logic                             r_eq_flag;
    logic                             r_gt_flag;
    logic                             cmp_gt;
    logic                             cmp_eq;

    assign cmp_gt = r_key > i_key;
    assign cmp_eq = r_key == i_key;
    assign o_gt   = i_in_use && cmp_gt;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && (o_gt || i_at_end)) begin
            n_key = i_left_gt ? i_left_key : i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctl.capture) begin
            r_eq_flag <= cmp_eq;
            r_gt_flag <= cmp_gt;
        end
    end

    assign o_key     = r_key;
    assign o_eq_flag = r_eq_flag;
    assign o_gt_flag = r_gt_flag;

endmodule

@@ src/sbs_search.sv @@
// ----------------------------------------------------------------------------
// sbs_search
// Binary search over the latched cell flags, one probe per cycle.
// ----------------------------------------------------------------------------
module sbs_search #(
    parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH,
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [CW-1:0]          i_count,
    input  logic [TABLE_DEPTH-1:0] i_eq,
    input  logic [TABLE_DEPTH-1:0] i_gt,
    output sbs_pkg::t_srch_res     o_res,
    output logic [AW-1:0]          o_mid
);

    logic          r_busy;
    logic          n_busy;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] n_lo;
    logic [CW-1:0] r_hix;
    logic [CW-1:0] n_hix;
    logic [CW-1:0] diff;
    logic [CW-1:0] mid_full;
    logic          empty;

    assign diff     = r_hix - r_lo - CW'(1);
    assign mid_full = r_lo + (diff >> 1);
    assign o_mid    = mid_full[AW-1:0];
    assign empty    = r_lo >= r_hix;

    always_comb begin
        n_busy      = r_busy;
        n_lo        = r_lo;
        n_hix       = r_hix;
        o_res.done  = 1'b0;
        o_res.found = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_lo   = '0;
            n_hix  = i_count;
        end else if (r_busy) begin
            if (empty) begin
                o_res.done = 1'b1;
                n_busy     = 1'b0;
            end else if (i_eq[o_mid]) begin
                o_res.done  = 1'b1;
                o_res.found = 1'b1;
                n_busy      = 1'b0;
            end else if (i_gt[o_mid]) begin
                n_hix = mid_full;
            end else begin
                n_lo = mid_full + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_lo  <= n_lo;
        r_hix <= n_hix;
    end

endmodule

@@ src/sorted_table_binary_search_top.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted table of signed keys held in a row of cells, with binary search.
// ----------------------------------------------------------------------------
// One request beat at a time. Clear and insert pass through the EXEC and PUSH
// states to the response register: the insert shifts every larger key one cell
// up in the EXEC state. A query latches compare flags in every cell in the EXEC
// state, then the search unit makes one probe per cycle, up to nine probes for
// 256 entries plus a final step that sees the range empty; the result is then
// loaded through the PUSH state, which waits while the output register is full
// and not being read. A new request is taken while the previous response
// still waits in the output register.
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH,
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbs_in_if.sink    i_req,
    sbs_out_if.source o_rsp
);

    sbs_pkg::t_state                  r_state;
    sbs_pkg::t_state                  n_state;
    sbs_pkg::t_action                 r_action;
    logic signed [sbs_pkg::KEY_W-1:0] r_key;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    sbs_pkg::t_status                 r_res_status;
    sbs_pkg::t_status                 n_res_status;
    logic [sbs_pkg::POS_W-1:0]        r_res_pos;
    logic [sbs_pkg::POS_W-1:0]        n_res_pos;
    logic                             r_out_valid;
    logic                             n_out_valid;
    sbs_pkg::t_status                 r_out_status;
    sbs_pkg::t_status                 n_out_status;
    logic [sbs_pkg::POS_W-1:0]        r_out_pos;
    logic [sbs_pkg::POS_W-1:0]        n_out_pos;

    sbs_pkg::t_cell_ctl               cell_ctl;
    sbs_pkg::t_srch_res               srch_res;
    logic                             srch_start;
    logic [AW-1:0]                    srch_mid;
    logic [AW+sbs_pkg::POS_W-1:0]     mid_ext;
    logic                             accept;
    logic                             full;

    logic signed [sbs_pkg::KEY_W-1:0] cell_key [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]           cell_gt;
    logic [TABLE_DEPTH-1:0]           eq_flags;
    logic [TABLE_DEPTH-1:0]           gt_flags;

    assign accept  = i_req.valid && i_req.ready;
    assign full    = r_count == CW'(TABLE_DEPTH);
    assign mid_ext = {sbs_pkg::POS_W'(0), srch_mid};

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(gi);
        logic signed [sbs_pkg::KEY_W-1:0] left_key;
        logic                             left_gt;

        if (gi == 0) begin : g_first
            assign left_key = r_key;
            assign left_gt  = 1'b0;
        end else begin : g_rest
            assign left_key = cell_key[gi-1];
            assign left_gt  = cell_gt[gi-1];
        end

        sbs_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_key      (r_key),
            .i_left_key (left_key),
            .i_left_gt  (left_gt),
            .i_in_use   (IDX < r_count),
            .i_at_end   (IDX == r_count),
            .o_key      (cell_key[gi]),
            .o_gt       (cell_gt[gi]),
            .o_eq_flag  (eq_flags[gi]),
            .o_gt_flag  (gt_flags[gi])
        );
    end

    sbs_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (srch_start),
        .i_count (r_count),
        .i_eq    (eq_flags),
        .i_gt    (gt_flags),
        .o_res   (srch_res),
        .o_mid   (srch_mid)
    );

    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_res_status     = r_res_status;
        n_res_pos        = r_res_pos;
        n_out_valid      = r_out_valid;
        n_out_status     = r_out_status;
        n_out_pos        = r_out_pos;
        cell_ctl.ins     = 1'b0;
        cell_ctl.capture = 1'b0;
        srch_start       = 1'b0;
        i_req.ready      = r_state == sbs_pkg::S_IDLE;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            sbs_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = sbs_pkg::S_EXEC;
                end
            end
            sbs_pkg::S_EXEC: begin
                n_res_pos = '0;
                n_state   = sbs_pkg::S_PUSH;
                case (r_action)
                    sbs_pkg::ACT_CLEAR: begin
                        n_count      = '0;
                        n_res_status = sbs_pkg::ST_DONE;
                    end
                    sbs_pkg::ACT_INSERT: begin
                        if (full) begin
                            n_res_status = sbs_pkg::ST_FULL;
                        end else begin
                            cell_ctl.ins = 1'b1;
                            n_count      = r_count + CW'(1);
                            n_res_status = sbs_pkg::ST_DONE;
                        end
                    end
                    sbs_pkg::ACT_QUERY: begin
                        cell_ctl.capture = 1'b1;
                        srch_start       = 1'b1;
                        n_state          = sbs_pkg::S_SEARCH;
                    end
                    default: begin
                        n_res_status = sbs_pkg::ST_MISSING;
                    end
                endcase
            end
            sbs_pkg::S_SEARCH: begin
                if (srch_res.done) begin
                    n_state = sbs_pkg::S_PUSH;
                    if (srch_res.found) begin
                        n_res_status = sbs_pkg::ST_FOUND;
                        n_res_pos    = mid_ext[sbs_pkg::POS_W-1:0];
                    end else begin
                        n_res_status = sbs_pkg::ST_MISSING;
                    end
                end
            end
            sbs_pkg::S_PUSH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pos    = r_res_pos;
                    n_state      = sbs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sbs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbs_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        if (accept) begin
            r_action <= sbs_pkg::t_action'(i_req.action);
            r_key    <= i_req.key_value;
        end
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.position = r_out_pos;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == sbs_pkg::S_EXEC)
        else $error("accepted beat not executed");

    a_search_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_res.done |-> r_state == sbs_pkg::S_SEARCH)
        else $error("search finished outside search state");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbs_pkg::S_EXEC && r_action == sbs_pkg::ACT_INSERT && !full)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not advance entry count");

endmodule
